// ----- hdl/mexp_pkg.sv -----
package mexp_pkg;

  // Operand width used for all arithmetic; the port fields stay 32 bits wide.
  localparam int WIDTH   = 32;
  localparam int FIELD_W = 32;
  localparam int PROD_W  = 2 * WIDTH;
  localparam int CNT_W   = $clog2(PROD_W);

  // Input request payload.
  typedef struct packed {
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus_value;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [FIELD_W-1:0] power_result;
    logic               zero_modulus;
  } out_t;

  // Request to the shared multiply-and-reduce unit.
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] op_a;
    logic [WIDTH-1:0] op_b;
    logic [WIDTH-1:0] modulus;
  } mm_req_t;

  // Status and result from the shared unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] remainder;
  } mm_rsp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

endpackage

// ----- hdl/mexp_mulmod.sv -----
module mexp_mulmod (
  input  logic             clk,
  input  logic             rst_n,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [mexp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [mexp_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [mexp_pkg::WIDTH-1:0]     rem_r, rem_nxt;
  logic [mexp_pkg::WIDTH-1:0]     mod_r, mod_nxt;
  logic [mexp_pkg::PROD_W-1:0]    prod_w;
  logic [mexp_pkg::WIDTH:0]       trial_w;
  logic [mexp_pkg::WIDTH:0]       diff_w;

  // Full double-width product of the two operands.
  assign prod_w = mexp_pkg::PROD_W'(req.op_a) * mexp_pkg::PROD_W'(req.op_b);

  // One restoring division step: shift in the next product bit and subtract if it fits.
  assign trial_w = {rem_r, prod_r[mexp_pkg::PROD_W-1]};
  assign diff_w  = trial_w - {1'b0, mod_r};

  // Sequencing of the multiply followed by the bit-serial reduction.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    mod_nxt  = mod_r;
    if (busy_r) begin
      prod_nxt = {prod_r[mexp_pkg::PROD_W-2:0], 1'b0};
      rem_nxt  = (trial_w >= {1'b0, mod_r}) ? diff_w[mexp_pkg::WIDTH-1:0]
                                             : trial_w[mexp_pkg::WIDTH-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == mexp_pkg::CNT_W'(mexp_pkg::PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      prod_nxt = prod_w;
      rem_nxt  = '0;
      mod_nxt  = req.modulus;
    end
  end

  // Control registers take reset; the datapath does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    mod_r  <= mod_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

  // The remainder must always stay below the modulus.
  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < mod_r))
    else $error("remainder not reduced below modulus");

  // A finished operation is reported in the first idle cycle after a busy period.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("done without a preceding busy period");

  // A start request is only taken while the unit is idle, and it always makes it busy.
  a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && !busy_r) |=> busy_r)
    else $error("start request not taken");

endmodule

// ----- hdl/modular_exponentiation.sv -----
// Channel | Ports                        | Payload type       | Moves
// input   | in_valid, in_ready, in_data  | mexp_pkg::in_t     | base, exponent, modulus
// result  | out_valid, out_ready, out_data | mexp_pkg::out_t  | power, zero-modulus flag
//
// The shared unit does each modular multiply as a product then a bit-serial reduction.
// A zero modulus or zero exponent skips the shared unit and goes straight to finishing.
// Reset is synchronous and clears the sequencer and the output valid flag.
// A result held by back-pressure delays only the next completion, not the next acceptance.
module modular_exponentiation (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mexp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mexp_pkg::out_t out_data
);

  mexp_pkg::state_t           state_r, state_nxt;
  logic [mexp_pkg::WIDTH-1:0] exp_r, exp_nxt;
  logic [mexp_pkg::WIDTH-1:0] base_r, base_nxt;
  logic [mexp_pkg::WIDTH-1:0] acc_r, acc_nxt;
  logic [mexp_pkg::WIDTH-1:0] mod_r, mod_nxt;
  logic                       err_r, err_nxt;
  logic                       out_valid_r, out_valid_nxt;
  mexp_pkg::out_t             out_data_r, out_data_nxt;
  mexp_pkg::mm_req_t          mm_req;
  mexp_pkg::mm_rsp_t          mm_rsp;
  logic [mexp_pkg::WIDTH-1:0] in_base_w, in_exp_w, in_mod_w;
  logic                       in_acc_w;
  logic                       out_acc_w;

  // Only the low WIDTH bits of each field take part.
  assign in_base_w = in_data.base_value[mexp_pkg::WIDTH-1:0];
  assign in_exp_w  = in_data.exponent[mexp_pkg::WIDTH-1:0];
  assign in_mod_w  = in_data.modulus_value[mexp_pkg::WIDTH-1:0];

  assign in_ready  = (state_r == mexp_pkg::ST_IDLE);
  assign in_acc_w  = in_valid && in_ready;
  assign out_acc_w = out_valid_r && out_ready;

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // State register and control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    exp_r      <= exp_nxt;
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    mod_r      <= mod_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  // Square-and-multiply sequencer driving the shared unit.
  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    mod_nxt       = mod_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mm_req.start   = 1'b0;
    mm_req.op_a    = base_r;
    mm_req.op_b    = base_r;
    mm_req.modulus = mod_r;

    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        mm_req.op_a    = in_base_w;
        mm_req.op_b    = mexp_pkg::WIDTH'(1);
        mm_req.modulus = in_mod_w;
        if (in_acc_w) begin
          exp_nxt = in_exp_w;
          mod_nxt = in_mod_w;
          err_nxt = 1'b0;
          acc_nxt = mexp_pkg::WIDTH'(1);
          if (in_mod_w == '0) begin
            // Zero modulus: flagged, result forced to zero.
            acc_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = mexp_pkg::ST_FINISH;
          end else if (in_exp_w == '0) begin
            // Zero exponent returns one without reduction.
            state_nxt = mexp_pkg::ST_FINISH;
          end else begin
            // Reduce the base first by multiplying it by one.
            mm_req.start = 1'b1;
            state_nxt    = mexp_pkg::ST_REDUCE;
          end
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mm_rsp.done) begin
          base_nxt  = mm_rsp.remainder;
          state_nxt = mexp_pkg::ST_STEP;
        end
      end
      mexp_pkg::ST_STEP: begin
        mm_req.start = 1'b1;
        if (exp_r[0]) begin
          mm_req.op_a = acc_r;
          state_nxt   = mexp_pkg::ST_MUL;
        end else begin
          state_nxt   = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_MUL: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.remainder;
          if (exp_r == mexp_pkg::WIDTH'(1)) begin
            // Last set bit: the final square is not needed.
            state_nxt = mexp_pkg::ST_FINISH;
          end else begin
            mm_req.start = 1'b1;
            state_nxt    = mexp_pkg::ST_SQR;
          end
        end
      end
      mexp_pkg::ST_SQR: begin
        if (mm_rsp.done) begin
          base_nxt = mm_rsp.remainder;
          exp_nxt  = exp_r >> 1;
          if ((exp_r >> 1) == '0) begin
            state_nxt = mexp_pkg::ST_FINISH;
          end else begin
            state_nxt = mexp_pkg::ST_STEP;
          end
        end
      end
      mexp_pkg::ST_FINISH: begin
        // Hand over once the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.power_result = mexp_pkg::FIELD_W'(acc_r);
          out_data_nxt.zero_modulus = err_r;
          state_nxt                 = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A zero-modulus result always carries a zero power.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.zero_modulus) |-> (out_data_r.power_result == '0))
    else $error("zero modulus result is not zero");

  // The unit is never started while it is still working.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mm_req.start |-> !mm_rsp.busy)
    else $error("shared unit started while busy");

  // A finished multiply only arrives while the sequencer is waiting for one.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == mexp_pkg::ST_REDUCE || state_r == mexp_pkg::ST_MUL ||
                     state_r == mexp_pkg::ST_SQR))
    else $error("unexpected completion from shared unit");

  // After a request is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc_w |=> !in_ready)
    else $error("ready after accepting a request");

  // A result is only loaded when the output register is free or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_FINISH && out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result lost");

endmodule

// ----- dv/mexp_checker.sv -----
`timescale 1ns / 1ps

module mexp_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  mexp_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  mexp_pkg::out_t out_data,
  output int             mismatches,
  output int             outstanding
);

  localparam int REPORT_LIMIT = 10;

  // Results still owed by the block, oldest first.
  mexp_pkg::out_t pending_powers[$];

  // Right-to-left square-and-multiply at double width, operands masked to WIDTH bits.
  function automatic mexp_pkg::out_t modpow(input mexp_pkg::in_t req);
    logic [63:0]    msk;
    logic [63:0]    b;
    logic [63:0]    e;
    logic [63:0]    m;
    logic [63:0]    acc;
    mexp_pkg::out_t res;
    msk = (64'd1 << mexp_pkg::WIDTH) - 64'd1;
    b   = {32'd0, req.base_value} & msk;
    e   = {32'd0, req.exponent} & msk;
    m   = {32'd0, req.modulus_value} & msk;
    acc = 64'd1;
    // A zero modulus has no defined answer, so the block flags it.
    if (m == 64'd0) begin
      res.power_result = '0;
      res.zero_modulus = 1'b1;
      return res;
    end
    b = b % m;
    while (e != 64'd0) begin
      if (e[0]) begin
        acc = (acc * b) % m;
      end
      b = (b * b) % m;
      e = e >> 1;
    end
    // A zero exponent leaves the accumulator at one, unreduced.
    acc = acc & msk;
    res.power_result = acc[mexp_pkg::FIELD_W-1:0];
    res.zero_modulus = 1'b0;
    return res;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Compare the result first: it can never belong to a request taken in the same cycle.
  always @(posedge clk) begin
    mexp_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_powers.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: result with no request outstanding: power %h flag %b",
                     $realtime, out_data.power_result, out_data.zero_modulus);
          end
        end else begin
          want = pending_powers.pop_front();
          if (out_data.power_result !== want.power_result ||
              out_data.zero_modulus !== want.zero_modulus) begin
            mismatches <= mismatches + 1;
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: result wrong: power exp %h got %h, zero_modulus exp %b got %b",
                       $realtime, want.power_result, out_data.power_result,
                       want.zero_modulus, out_data.zero_modulus);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_powers.insert(pending_powers.size(), modpow(in_data));
      end
      outstanding <= pending_powers.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // Longest quiet spell: one full 32-bit exponent plus both stall bursts, with margin.
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_REQUESTS = 250;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  mexp_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  mexp_pkg::out_t out_data;
  int             mismatches;
  int             outstanding;
  int             quiet_cycles;
  bit             steady;
  mexp_pkg::in_t  directed_q[$];

  modular_exponentiation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mexp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on cycles in which neither channel moves anything.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure bursts unless a steady stretch is running.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic mexp_pkg::in_t make_request(input logic [31:0] b, input logic [31:0] e,
                                                 input logic [31:0] m);
    mexp_pkg::in_t req;
    req.base_value    = b;
    req.exponent      = e;
    req.modulus_value = m;
    return req;
  endfunction

  // Append one directed request to the list sent before the random ones.
  task automatic queue_directed(input logic [31:0] b, input logic [31:0] e,
                                input logic [31:0] m);
    directed_q.insert(directed_q.size(), make_request(b, e, m));
  endtask

  // Random operands: exponent lengths vary so most requests stay short.
  function automatic mexp_pkg::in_t random_request();
    mexp_pkg::in_t req;
    int            pick;
    pick = $urandom_range(0, 19);
    req.base_value    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
    req.exponent      = ($urandom_range(0, 4) == 0) ? $urandom
                                                    : ($urandom >> $urandom_range(1, 31));
    req.modulus_value = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(2, 1000);
    case (pick)
      0: req.modulus_value = '0;
      1: req.modulus_value = 32'd1;
      2: req.exponent      = '0;
      default: ;
    endcase
    return req;
  endfunction

  // Present one request, after an optional idle burst, and hold it until taken.
  task automatic send_request(input mexp_pkg::in_t req);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending until the block has returned every result.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    steady   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero modulus, zero exponent, modulus of one and operand extremes.
    queue_directed(32'd0, 32'd0, 32'd0);
    queue_directed(ALL_ONES, ALL_ONES, 32'd0);
    queue_directed(32'd5, 32'd0, 32'd1);
    queue_directed(ALL_ONES, 32'd0, 32'd1);
    queue_directed(32'd7, 32'd0, 32'd13);
    queue_directed(32'd0, 32'd0, ALL_ONES);
    queue_directed(32'd7, 32'd1, 32'd1);
    queue_directed(ALL_ONES, ALL_ONES, 32'd1);
    queue_directed(32'd0, 32'd5, 32'd7);
    queue_directed(ALL_ONES, 32'd1, ALL_ONES);
    queue_directed(ALL_ONES, ALL_ONES, ALL_ONES);
    queue_directed(ALL_ONES, ALL_ONES, 32'hFFFF_FFFE);
    queue_directed(ALL_ONES, ALL_ONES, 32'hFFFF_FFFB);
    queue_directed(32'd2, 32'd31, ALL_ONES);
    queue_directed(32'd3, 32'd200, 32'd1000);
    queue_directed(32'd1, ALL_ONES, 32'd2);
    queue_directed(ALL_ONES, 32'd2, 32'h8000_0000);
    queue_directed(32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFB);
    queue_directed(32'hDEAD_BEEF, 32'h5555_5555, 32'h7FFF_FFFF);
    queue_directed(32'h8000_0000, 32'hAAAA_AAAA, 32'd3);
    foreach (directed_q[i]) send_request(directed_q[i]);
    drain_results();

    // Random requests, with a steady stretch in the middle and none of the idling at the end.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i >= 100 && i < 130) || (i >= RANDOM_REQUESTS - 40);
      if (i == 135) begin
        drain_results();
      end
      send_request(random_request());
    end

    // Let the last results arrive, then allow for any stray output.
    drain_results();
    repeat (64) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
